// ----- design/gmm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and a helper function for the grayscale morphology filter.
package gmm_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_RADIUS  = 3;
   localparam int WIN         = 2 * MAX_RADIUS + 1;
   localparam int SLOTS       = 2 * MAX_RADIUS;
   localparam int WIN_IDX_W   = $clog2(WIN);
   localparam int PIX_W       = 8;
   localparam int COORD_W     = 10;
   localparam int SIZE_W      = 11;
   localparam int RAD_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_DILATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONN_SQUARE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd4;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WIN-1:0] column_type;
   typedef pix_type [SLOTS-1:0] line_word_type;

   typedef struct packed {
      logic               mode_dilate;
      logic               connectivity_square;
      logic [RAD_W-1:0]   radius;
      logic [SIZE_W-1:0]  image_width;
      logic [SIZE_W-1:0]  image_height;
   } cfg_type;

   typedef struct packed {
      logic               emit;
      logic               border;
      logic               frame_last;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
   } info_type;

   typedef struct packed {
      column_type column;
      info_type   info;
   } item_type;

   function automatic pix_type pick(input pix_type a, input pix_type b, input logic take_max);
      if (take_max) begin
         return (b > a) ? b : a;
      end else begin
         return (b < a) ? b : a;
      end
   endfunction

endpackage

// ----- design/gmm_front.sv -----
`timescale 1ns / 1ps
// Front end: raster counters, item classification and the column line store.
module gmm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  gmm_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gmm_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic                        req_frame_start,
   input  logic                        q_ready,
   output logic                        q_push,
   output gmm_pkg::item_type           q_item
);

   logic [gmm_pkg::COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [gmm_pkg::COORD_W-1:0] cur_row, cur_col, rad_c, rad2_c;
   logic [gmm_pkg::SIZE_W-1:0]  w_eff, h_eff, row_next, col_next;
   logic                        accept;
   gmm_pkg::info_type           info;

   logic                        s2_valid_ff, s2_valid_in;
   logic                        byp_ff, byp_in;
   gmm_pkg::pix_type            s2_pix_ff;
   gmm_pkg::info_type           s2_info_ff;
   logic [gmm_pkg::COORD_W-1:0] s2_addr_ff;
   gmm_pkg::line_word_type      rd_word_ff, byp_word_ff, used_word, wr_word;
   gmm_pkg::line_word_type      line_mem [gmm_pkg::MAX_WIDTH];

   assign req_ready = !s2_valid_ff || q_ready;
   assign accept    = req_valid && req_ready;
   assign q_push    = s2_valid_ff && q_ready;

   always_comb begin
      cur_row = req_frame_start ? '0 : row_ff;
      cur_col = req_frame_start ? '0 : col_ff;

      if (cfg.image_width == '0) begin
         w_eff = gmm_pkg::SIZE_W'(1);
      end else if (cfg.image_width > gmm_pkg::SIZE_W'(gmm_pkg::MAX_WIDTH)) begin
         w_eff = gmm_pkg::SIZE_W'(gmm_pkg::MAX_WIDTH);
      end else begin
         w_eff = cfg.image_width;
      end
      if (cfg.image_height == '0) begin
         h_eff = gmm_pkg::SIZE_W'(1);
      end else if (cfg.image_height > gmm_pkg::SIZE_W'(gmm_pkg::MAX_HEIGHT)) begin
         h_eff = gmm_pkg::SIZE_W'(gmm_pkg::MAX_HEIGHT);
      end else begin
         h_eff = cfg.image_height;
      end

      rad_c  = gmm_pkg::COORD_W'(cfg.radius);
      rad2_c = gmm_pkg::COORD_W'({cfg.radius, 1'b0});

      info.emit       = (cur_row >= rad_c) && (cur_col >= rad_c)
                        && ({1'b0, cur_row} < h_eff) && ({1'b0, cur_col} < w_eff);
      info.border     = (cur_row < rad2_c) || (cur_col < rad2_c);
      info.frame_last = ({1'b0, cur_row} == h_eff - gmm_pkg::SIZE_W'(1))
                        && ({1'b0, cur_col} == w_eff - gmm_pkg::SIZE_W'(1));
      info.out_row    = cur_row - rad_c;
      info.out_col    = cur_col - rad_c;

      row_next = {1'b0, cur_row} + gmm_pkg::SIZE_W'(1);
      col_next = {1'b0, cur_col} + gmm_pkg::SIZE_W'(1);
      row_in   = row_ff;
      col_in   = col_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (row_next >= h_eff) ? '0 : row_next[gmm_pkg::COORD_W-1:0];
         end else begin
            row_in = cur_row;
            col_in = col_next[gmm_pkg::COORD_W-1:0];
         end
      end

      s2_valid_in = accept || (s2_valid_ff && !q_push);
      byp_in      = accept ? (q_push && (s2_addr_ff == cur_col)) : byp_ff;
   end

   // Each line store word holds the last rows seen at one column, oldest first.
   always_comb begin
      used_word = byp_ff ? byp_word_ff : rd_word_ff;
      for (int s = 0; s < gmm_pkg::SLOTS - 1; s++) begin
         wr_word[s] = used_word[s+1];
      end
      wr_word[gmm_pkg::SLOTS-1] = s2_pix_ff;
      for (int s = 0; s < gmm_pkg::SLOTS; s++) begin
         q_item.column[s] = used_word[s];
      end
      q_item.column[gmm_pkg::WIN-1] = s2_pix_ff;
      q_item.info = s2_info_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s2_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s2_valid_ff <= s2_valid_in;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_pix_ff   <= req_pixel_in;
         s2_info_ff  <= info;
         s2_addr_ff  <= cur_col;
         byp_word_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         line_mem[s2_addr_ff] <= wr_word;
      end
      if (accept) begin
         rd_word_ff <= line_mem[cur_col];
      end
   end

endmodule

// ----- design/gmm_queue.sv -----
`timescale 1ns / 1ps
// Short item queue between the front end and the window back end.
module gmm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gmm_pkg::item_type push_item,
   output logic              ready,
   output logic              valid,
   input  logic              pop,
   output gmm_pkg::item_type pop_item
);

   gmm_pkg::item_type          entry_ff [gmm_pkg::QUEUE_DEPTH];
   logic [gmm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [gmm_pkg::QCNT_W-1:0] count_ff, count_in;

   assign ready    = (count_ff != gmm_pkg::QCNT_W'(gmm_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + gmm_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + gmm_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + gmm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - gmm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/gmm_back.sv -----
`timescale 1ns / 1ps
// Back end: register window, two-stage min/max tree and result register.
module gmm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  gmm_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  gmm_pkg::item_type           q_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gmm_pkg::PIX_W-1:0]   rsp_pixel_out,
   output logic [gmm_pkg::COORD_W-1:0] rsp_out_row,
   output logic [gmm_pkg::COORD_W-1:0] rsp_out_col,
   output logic                        rsp_frame_last
);

   gmm_pkg::pix_type [gmm_pkg::WIN-1:0][gmm_pkg::WIN-1:0] window_ff;
   logic                          w_valid_ff, w_valid_in;
   gmm_pkg::info_type             w_info_ff;
   logic                          r_valid_ff, r_valid_in;
   gmm_pkg::info_type             r_info_ff;
   gmm_pkg::column_type           r_row_ff, r_cc_ff, row_red, cc_val;
   logic                          o_valid_ff, o_valid_in;
   gmm_pkg::pix_type              o_pix_ff, o_pix_in, final_val, ident;
   gmm_pkg::info_type             o_info_ff;
   logic                          o_free, r_free, r_adv, w_free, w_adv;
   logic [gmm_pkg::WIN_IDX_W-1:0] lo, ctr;

   always_comb begin
      o_free = !o_valid_ff || rsp_ready;
      r_adv  = r_valid_ff && o_free;
      r_free = !r_valid_ff || o_free;
      w_adv  = w_valid_ff && r_free;
      w_free = !w_valid_ff || r_free;
      q_pop  = q_valid && w_free;

      w_valid_in = q_pop || (w_valid_ff && !w_adv);
      r_valid_in = w_adv || (r_valid_ff && !r_adv);
      o_valid_in = (r_adv && r_info_ff.emit) || (o_valid_ff && !rsp_ready);
   end

   always_comb begin
      ident = cfg.mode_dilate ? '0 : '1;
      lo    = gmm_pkg::WIN_IDX_W'(gmm_pkg::WIN - 1) - gmm_pkg::WIN_IDX_W'({cfg.radius, 1'b0});
      ctr   = gmm_pkg::WIN_IDX_W'(gmm_pkg::WIN - 1) - gmm_pkg::WIN_IDX_W'(cfg.radius);
      for (int i = 0; i < gmm_pkg::WIN; i++) begin
         row_red[i] = ident;
         for (int j = 0; j < gmm_pkg::WIN; j++) begin
            if (gmm_pkg::WIN_IDX_W'(j) >= lo) begin
               row_red[i] = gmm_pkg::pick(row_red[i], window_ff[i][j], cfg.mode_dilate);
            end
         end
         cc_val[i] = window_ff[i][ctr];
      end

      final_val = ident;
      for (int i = 0; i < gmm_pkg::WIN; i++) begin
         if (gmm_pkg::WIN_IDX_W'(i) >= lo) begin
            final_val = gmm_pkg::pick(final_val,
                                      cfg.connectivity_square ? r_row_ff[i] : r_cc_ff[i],
                                      cfg.mode_dilate);
         end
      end
      if (!cfg.connectivity_square) begin
         final_val = gmm_pkg::pick(final_val, r_row_ff[ctr], cfg.mode_dilate);
      end
      o_pix_in = r_info_ff.border ? '0 : final_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         w_valid_ff <= w_valid_in;
         r_valid_ff <= r_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < gmm_pkg::WIN; i++) begin
            for (int j = 0; j < gmm_pkg::WIN - 1; j++) begin
               window_ff[i][j] <= window_ff[i][j+1];
            end
            window_ff[i][gmm_pkg::WIN-1] <= q_item.column[i];
         end
         w_info_ff <= q_item.info;
      end
      if (w_adv) begin
         r_row_ff  <= row_red;
         r_cc_ff   <= cc_val;
         r_info_ff <= w_info_ff;
      end
      if (r_adv && r_info_ff.emit) begin
         o_pix_ff  <= o_pix_in;
         o_info_ff <= r_info_ff;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_pixel_out  = o_pix_ff;
   assign rsp_out_row    = o_info_ff.out_row;
   assign rsp_out_col    = o_info_ff.out_col;
   assign rsp_frame_last = o_info_ff.frame_last;

endmodule

// ----- design/grayscale_morphology_min_max_filter.sv -----
`timescale 1ns / 1ps
// Top level of the streaming grayscale erosion and dilation filter.
// The filter takes one pixel per clock in raster order and sustains one item per
// clock as long as results are taken. That rate is set by the line store, a single
// memory of one word per column holding the previous six rows, read and rewritten
// once per item. The line store has no clearing pass and holds garbage until the
// first full rows of a frame are written, so the user must change size and radius
// registers only between frames; the block itself does not enforce this.
module grayscale_morphology_min_max_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gmm_pkg::PIX_W-1:0]     req_pixel_in,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gmm_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [gmm_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [gmm_pkg::COORD_W-1:0]   rsp_out_col,
   output logic                          rsp_frame_last,
   input  logic                          csr_we,
   input  logic [gmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   gmm_pkg::cfg_type  cfg_ff, cfg_in;
   logic              q_push, q_ready, q_valid, q_pop;
   gmm_pkg::item_type push_item, pop_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            gmm_pkg::CSR_MODE_DILATE:  cfg_in.mode_dilate = csr_wdata[0];
            gmm_pkg::CSR_CONN_SQUARE:  cfg_in.connectivity_square = csr_wdata[0];
            gmm_pkg::CSR_RADIUS:       cfg_in.radius = csr_wdata[gmm_pkg::RAD_W-1:0];
            gmm_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width = csr_wdata[gmm_pkg::SIZE_W-1:0];
            gmm_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata[gmm_pkg::SIZE_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_dilate         <= 1'b0;
         cfg_ff.connectivity_square <= 1'b1;
         cfg_ff.radius              <= gmm_pkg::RAD_W'(1);
         cfg_ff.image_width         <= gmm_pkg::SIZE_W'(640);
         cfg_ff.image_height        <= gmm_pkg::SIZE_W'(480);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gmm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .q_ready         (q_ready),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   gmm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .ready     (q_ready),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_item  (pop_item)
   );

   gmm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_item         (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
